@@ rtl/bvtp_pkg.sv @@
// Shared types, curve tables and reciprocal constants for the battery level block.
package bvtp_pkg;

  localparam int unsigned NUM_PTS = 12;

  typedef logic [12:0] mv_t;
  typedef logic [13:0] cp_t;
  typedef logic [1:0]  chem_t;
  typedef logic [3:0]  seg_idx_t;
  typedef logic [7:0]  off_t;
  typedef logic [9:0]  dp_t;
  typedef logic [22:0] rcp_t;
  typedef logic [17:0] prod_t;
  typedef logic [9:0]  quot_t;

  localparam chem_t CHEM_LIION = 2'd0;
  localparam chem_t CHEM_LFP   = 2'd1;

  localparam seg_idx_t LIION_LAST = 4'd10;
  localparam seg_idx_t LFP_LAST   = 4'd11;

  localparam cp_t LEVEL_FULL = 14'd10000;

  // floor(p / dv) == (p * ceil(2^S / dv)) >> S for p < 2^18 and dv < 2^8
  localparam int unsigned RCP_SHIFT = 26;
  localparam int unsigned RCP_ONE   = 2 ** RCP_SHIFT;

  localparam mv_t LIION_MV [NUM_PTS] = '{
    13'd3200, 13'd3400, 13'd3580, 13'd3680, 13'd3740, 13'd3790,
    13'd3850, 13'd3920, 13'd4000, 13'd4100, 13'd4160, 13'd4160};
  localparam cp_t LIION_CP [NUM_PTS] = '{
    14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000, 14'd5000,
    14'd6000, 14'd7000, 14'd8000, 14'd9000, 14'd10000, 14'd10000};

  localparam mv_t LFP_MV [NUM_PTS] = '{
    13'd2800, 13'd3000, 13'd3100, 13'd3180, 13'd3220, 13'd3250,
    13'd3270, 13'd3280, 13'd3300, 13'd3320, 13'd3350, 13'd3450};
  localparam cp_t LFP_CP [NUM_PTS] = '{
    14'd0, 14'd500, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
    14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000, 14'd10000};

  // Segment i spans breakpoints i-1 .. i; entry 0 is unused.
  localparam dp_t LIION_DP [NUM_PTS] = '{
    10'd0, 10'd1000, 10'd1000, 10'd1000, 10'd1000, 10'd1000,
    10'd1000, 10'd1000, 10'd1000, 10'd1000, 10'd1000, 10'd0};
  localparam dp_t LFP_DP [NUM_PTS] = '{
    10'd0, 10'd500, 10'd500, 10'd1000, 10'd1000, 10'd1000,
    10'd1000, 10'd1000, 10'd1000, 10'd1000, 10'd1000, 10'd1000};

  localparam rcp_t LIION_RCP [NUM_PTS] = '{
    23'd0,
    23'((RCP_ONE + 199) / 200),
    23'((RCP_ONE + 179) / 180),
    23'((RCP_ONE + 99) / 100),
    23'((RCP_ONE + 59) / 60),
    23'((RCP_ONE + 49) / 50),
    23'((RCP_ONE + 59) / 60),
    23'((RCP_ONE + 69) / 70),
    23'((RCP_ONE + 79) / 80),
    23'((RCP_ONE + 99) / 100),
    23'((RCP_ONE + 59) / 60),
    23'd0};
  localparam rcp_t LFP_RCP [NUM_PTS] = '{
    23'd0,
    23'((RCP_ONE + 199) / 200),
    23'((RCP_ONE + 99) / 100),
    23'((RCP_ONE + 79) / 80),
    23'((RCP_ONE + 39) / 40),
    23'((RCP_ONE + 29) / 30),
    23'((RCP_ONE + 19) / 20),
    23'((RCP_ONE + 9) / 10),
    23'((RCP_ONE + 19) / 20),
    23'((RCP_ONE + 19) / 20),
    23'((RCP_ONE + 29) / 30),
    23'((RCP_ONE + 99) / 100)};

  // Segment lookup result handed to the multiply stages.
  typedef struct packed {
    off_t  off;
    dp_t   dp;
    rcp_t  rcp;
    cp_t   base;
    logic  level_valid;
  } seg_t;

endpackage

@@ rtl/bvtp_in_if.sv @@
// Voltage sample channel.
interface bvtp_in_if;
  logic              valid;
  logic              ready;
  bvtp_pkg::mv_t     voltage_mv;
  logic              voltage_valid;

  modport source (output valid, output voltage_mv, output voltage_valid, input ready);
  modport sink   (input valid, input voltage_mv, input voltage_valid, output ready);
endinterface

@@ rtl/bvtp_out_if.sv @@
// Charge level result channel.
interface bvtp_out_if;
  logic              valid;
  logic              ready;
  bvtp_pkg::cp_t     level_centipercent;
  logic              level_valid;

  modport source (output valid, output level_centipercent, output level_valid, input ready);
  modport sink   (input valid, input level_centipercent, input level_valid, output ready);
endinterface

@@ rtl/bvtp_cfg_if.sv @@
// Configuration write channel for the chemistry select register.
interface bvtp_cfg_if;
  logic              valid;
  logic              ready;
  bvtp_pkg::chem_t   chemistry_select;

  modport source (output valid, output chemistry_select, input ready);
  modport sink   (input valid, input chemistry_select, output ready);
endinterface

@@ rtl/bvtp_segment.sv @@
// Breakpoint search: picks the curve segment and its interpolation constants.
module bvtp_segment (
  input  bvtp_pkg::mv_t   voltage_mv,
  input  logic            voltage_valid,
  input  bvtp_pkg::chem_t chem,
  output bvtp_pkg::seg_t  seg
);

  bvtp_pkg::mv_t     vt [bvtp_pkg::NUM_PTS];
  bvtp_pkg::seg_idx_t last;
  bvtp_pkg::seg_idx_t idx;
  bvtp_pkg::seg_idx_t idx_lo;
  logic              sel_lfp;
  logic              below;
  logic              above;
  bvtp_pkg::mv_t     diff;

  assign sel_lfp = (chem == bvtp_pkg::CHEM_LFP);

  always_comb begin
    for (int k = 0; k < bvtp_pkg::NUM_PTS; k++) begin
      vt[k] = sel_lfp ? bvtp_pkg::LFP_MV[k] : bvtp_pkg::LIION_MV[k];
    end
    last  = sel_lfp ? bvtp_pkg::LFP_LAST : bvtp_pkg::LIION_LAST;
    below = (voltage_mv <= vt[0]);
    above = sel_lfp ? (voltage_mv >= bvtp_pkg::LFP_MV[bvtp_pkg::LFP_LAST])
                    : (voltage_mv >= bvtp_pkg::LIION_MV[bvtp_pkg::LIION_LAST]);
    // take the first breakpoint at or above the sample
    idx = last;
    for (int i = bvtp_pkg::NUM_PTS - 1; i >= 1; i--) begin
      if ((bvtp_pkg::seg_idx_t'(i) <= last) && (voltage_mv <= vt[i])) begin
        idx = bvtp_pkg::seg_idx_t'(i);
      end
    end
  end

  assign idx_lo = idx - 4'd1;
  assign diff   = voltage_mv - vt[idx_lo];

  always_comb begin
    seg.level_valid = voltage_valid;
    seg.dp   = sel_lfp ? bvtp_pkg::LFP_DP[idx]  : bvtp_pkg::LIION_DP[idx];
    seg.rcp  = sel_lfp ? bvtp_pkg::LFP_RCP[idx] : bvtp_pkg::LIION_RCP[idx];
    seg.off  = diff[$bits(bvtp_pkg::off_t)-1:0];
    seg.base = sel_lfp ? bvtp_pkg::LFP_CP[idx_lo] : bvtp_pkg::LIION_CP[idx_lo];
    // zero offset turns the interpolation into a plain constant
    if (!voltage_valid || below) begin
      seg.off  = '0;
      seg.base = '0;
    end else if (above) begin
      seg.off  = '0;
      seg.base = bvtp_pkg::LEVEL_FULL;
    end
  end

endmodule

@@ rtl/battery_voltage_to_percent_top.sv @@
// Top level: battery voltage to charge level, four-stage pipeline.
//
// Channels:
//   sample - voltage words (voltage_mv, voltage_valid), valid/ready.
//   level  - result words (level_centipercent, level_valid), valid/ready.
//   cfg    - chemistry_select writes (0 Li-ion, 1 LiFePO4, else Li-ion);
//            always ready, write only while the pipeline is empty.
// Each sample yields exactly one result word, in order. An invalid sample
// gives level_valid 0 with level 0.
// Each word is registered in s1, s2, s3 and then the output register that
// drives level. Throughput: one word per cycle while level.ready is high.
// The stages are segment search, offset times slope step, multiply by the
// segment's reciprocal, and base add into the output register; the two
// multipliers set the stage depth.
// Reset clears every stage valid bit and sets chemistry_select to Li-ion.
// When the receiver stalls, each stage holds its word and the stall backs
// up stage by stage; sample.ready drops only once every stage is full.
module battery_voltage_to_percent_top (
  input  logic clk,
  input  logic rst,
  bvtp_in_if.sink    sample,
  bvtp_out_if.source level,
  bvtp_cfg_if.sink   cfg
);

  bvtp_pkg::chem_t chem;

  bvtp_pkg::seg_t  seg_comb;
  bvtp_pkg::seg_t  s1;
  logic            s1_valid;

  bvtp_pkg::prod_t s2_prod;
  bvtp_pkg::rcp_t  s2_rcp;
  bvtp_pkg::cp_t   s2_base;
  logic            s2_lv;
  logic            s2_valid;

  bvtp_pkg::quot_t s3_quot;
  bvtp_pkg::cp_t   s3_base;
  logic            s3_lv;
  logic            s3_valid;

  bvtp_pkg::cp_t   o_level;
  logic            o_lv;
  logic            o_valid;

  logic o_ready;
  logic s3_ready;
  logic s2_ready;
  logic s1_ready;

  logic [$bits(bvtp_pkg::prod_t)+$bits(bvtp_pkg::rcp_t)-1:0] s2_scaled;
  bvtp_pkg::quot_t                                          s2_quot;

  // Configuration: single register, write always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chem <= bvtp_pkg::CHEM_LIION;
    end else if (cfg.valid) begin
      chem <= cfg.chemistry_select;
    end
  end

  // Backpressure chain: a stage takes a word when empty or draining.
  assign o_ready  = !o_valid  || level.ready;
  assign s3_ready = !s3_valid || o_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign sample.ready = s1_ready;

  // Stage 1: segment search.
  bvtp_segment u_segment (
    .voltage_mv    (sample.voltage_mv),
    .voltage_valid (sample.voltage_valid),
    .chem          (chem),
    .seg           (seg_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && sample.valid) begin
      s1 <= seg_comb;
    end
  end

  // Stage 2: offset times slope numerator.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_prod <= bvtp_pkg::prod_t'(s1.off) * bvtp_pkg::prod_t'(s1.dp);
      s2_rcp  <= s1.rcp;
      s2_base <= s1.base;
      s2_lv   <= s1.level_valid;
    end
  end

  // Stage 3: divide by the segment width through its reciprocal.
  assign s2_scaled = $bits(s2_scaled)'(s2_prod) * $bits(s2_scaled)'(s2_rcp);
  assign s2_quot   = s2_scaled[bvtp_pkg::RCP_SHIFT +: $bits(bvtp_pkg::quot_t)];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_quot <= s2_quot;
      s3_base <= s2_base;
      s3_lv   <= s2_lv;
    end
  end

  // Stage 4: add the segment base into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_ready) begin
      o_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && s3_valid) begin
      o_level <= s3_base + bvtp_pkg::cp_t'(s3_quot);
      o_lv    <= s3_lv;
    end
  end

  assign level.valid              = o_valid;
  assign level.level_centipercent = o_level;
  assign level.level_valid        = o_lv;

  // An invalid sample must come out as level zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_lv |-> o_level == '0)
    else $error("invalid sample produced nonzero level");

  // Level never exceeds full charge.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> o_level <= bvtp_pkg::LEVEL_FULL)
    else $error("level above full charge");

  // Input stalls only when every stage holds a word.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s1_ready |-> s1_valid && s2_valid && s3_valid && o_valid)
    else $error("input stalled with an empty stage");

  // A stage word that cannot advance is kept.
  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    s3_valid && !o_ready |=> s3_valid && $stable(s3_quot) && $stable(s3_base))
    else $error("stage 3 word lost under stall");

endmodule
